// ----- rtl/itoa_pkg.sv -----
// Shared types, constants and helpers of the integer to ASCII formatter.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package itoa_pkg;

   // Format select codes carried in the request tuser bit.
   localparam logic OP_HEX = 1'b0;
   localparam logic OP_DEC = 1'b1;

   localparam int VALUE_WIDTH  = 32;
   localparam int CHAR_WIDTH   = 8;
   localparam int DIGIT_COUNT  = 10;
   localparam int NIBBLE_WIDTH = 4;
   localparam int POS_WIDTH    = 4;

   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X    = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_A    = 8'h41;

   localparam logic [NIBBLE_WIDTH-1:0] DEC_BASE     = 4'd10;
   localparam logic [NIBBLE_WIDTH-1:0] DIGIT_MAX    = 4'd9;
   localparam logic [NIBBLE_WIDTH-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [NIBBLE_WIDTH-1:0] DABBLE_ADD   = 4'd3;

   // Character positions of a hexadecimal run: "0", "x", then eight digits.
   localparam logic [POS_WIDTH-1:0] HEX_POS_ZERO = 4'd0;
   localparam logic [POS_WIDTH-1:0] HEX_POS_X    = 4'd1;
   localparam logic [POS_WIDTH-1:0] HEX_POS_LAST = 4'd9;

   typedef logic [DIGIT_COUNT-1:0][NIBBLE_WIDTH-1:0] itoa_digits_type;

   // One queued number: its format and its ten nibbles (hex value or BCD).
   typedef struct packed {
      logic            mode;
      itoa_digits_type digits;
   } itoa_entry_type;

   function automatic logic [CHAR_WIDTH-1:0] nibble_to_ascii(
      input logic [NIBBLE_WIDTH-1:0] nib
   );
      logic [CHAR_WIDTH-1:0] wide;
      wide = {{(CHAR_WIDTH-NIBBLE_WIDTH){1'b0}}, nib};
      if (nib > DIGIT_MAX) begin
         return CHAR_A + wide - {{(CHAR_WIDTH-NIBBLE_WIDTH){1'b0}}, DEC_BASE};
      end
      return CHAR_ZERO + wide;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_formatter_unit.sv -----
// Top level of the integer to ASCII formatter: front end, queue, back end.
// Depends on itoa_pkg, itoa_front, itoa_queue and itoa_back.
//
// Each request item carries a 32-bit value in tdata and the format in tuser
// (0 hexadecimal with a "0x" prefix and eight upper-case digits, 1 unsigned
// decimal with no leading zeros). The block answers with one response item
// per ASCII character, most significant first, tlast set on the final one;
// a hex number gives ten characters, a decimal number one to ten. A hex
// request passes the front end with no conversion; a decimal request
// occupies it while the binary to BCD loop runs, which handles one bit per
// cycle. The back end loads each number from the queue, then emits one
// character per cycle while the consumer accepts them. The queue lets the
// next number convert while the previous one is still being sent.
`default_nettype none

module integer_to_ascii_formatter_unit #(
   parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tuser,   // [0] opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] character
   output logic             rsp_tlast
);

   logic                     push_valid, push_ready;
   logic                     pop_valid, pop_ready;
   itoa_pkg::itoa_entry_type push_entry, pop_entry;

   itoa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser),
      .req_value  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   itoa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   itoa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- rtl/itoa_front.sv -----
// Front end: accepts a number, converts decimal requests to BCD by a
// shift-and-add-3 loop, one bit per cycle, and pushes the entry to the queue.
// Depends on itoa_pkg.
`default_nettype none

module itoa_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_mode,
   input  wire logic [itoa_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output itoa_pkg::itoa_entry_type               push_entry
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   localparam int CNT_WIDTH = $clog2(itoa_pkg::VALUE_WIDTH);
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(itoa_pkg::VALUE_WIDTH - 1);
   localparam int PAD_WIDTH =
      itoa_pkg::DIGIT_COUNT * itoa_pkg::NIBBLE_WIDTH - itoa_pkg::VALUE_WIDTH;

   logic [1:0]                       state_ff, state_in;
   logic [CNT_WIDTH-1:0]             cnt_ff, cnt_in;
   logic                             mode_ff, mode_in;
   logic [itoa_pkg::VALUE_WIDTH-1:0] bin_ff, bin_in;
   itoa_pkg::itoa_digits_type        bcd_ff, bcd_in;
   itoa_pkg::itoa_digits_type        bcd_adj;

   assign req_ready        = (state_ff == ST_IDLE);
   assign push_valid       = (state_ff == ST_PUSH);
   assign push_entry.mode  = mode_ff;
   assign push_entry.digits = bcd_ff;

   always_comb begin
      for (int i = 0; i < itoa_pkg::DIGIT_COUNT; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= itoa_pkg::DABBLE_LIMIT) ?
                      bcd_ff[i] + itoa_pkg::DABBLE_ADD : bcd_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               cnt_in  = '0;
               if (req_mode == itoa_pkg::OP_HEX) begin
                  // Hex needs no conversion: the value goes out nibble by nibble.
                  bcd_in   = itoa_pkg::itoa_digits_type'({{PAD_WIDTH{1'b0}}, req_value});
                  state_in = ST_PUSH;
               end else begin
                  bin_in   = req_value;
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            // The top digit of a 32-bit value never exceeds 4, so the bit
            // shifted out of the BCD word is always zero.
            {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
   end

endmodule

`default_nettype wire

// ----- rtl/itoa_queue.sv -----
// Short first-in first-out queue of formatted-number entries that decouples
// the converting front end from the character emitter. Depends on itoa_pkg.
`default_nettype none

module itoa_queue #(
   parameter int DEPTH = itoa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   output logic                            push_ready,
   input  wire itoa_pkg::itoa_entry_type   push_entry,
   output logic                            pop_valid,
   input  wire logic                       pop_ready,
   output itoa_pkg::itoa_entry_type        pop_entry
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

   itoa_pkg::itoa_entry_type entries_ff [DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]     count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/itoa_back.sv -----
// Back end: takes one queued entry at a time and emits its characters, one per
// cycle unless stalled, through a registered output stage. Depends on itoa_pkg.
`default_nettype none

module itoa_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               pop_valid,
   output logic                                    pop_ready,
   input  wire itoa_pkg::itoa_entry_type           pop_entry,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output logic [itoa_pkg::CHAR_WIDTH-1:0]         out_char,
   output logic                                    out_last
);

   logic                                 active_ff, active_in;
   logic                                 mode_ff, mode_in;
   itoa_pkg::itoa_digits_type            digits_ff, digits_in;
   logic [itoa_pkg::POS_WIDTH-1:0]       pos_ff, pos_in;
   logic                                 valid_ff, valid_in;
   logic [itoa_pkg::CHAR_WIDTH-1:0]      char_ff, char_in;
   logic                                 last_ff, last_in;

   logic [itoa_pkg::POS_WIDTH-1:0]       top_pos;
   logic [itoa_pkg::POS_WIDTH-1:0]       hex_idx;
   logic [itoa_pkg::CHAR_WIDTH-1:0]      cur_char;
   logic                                 cur_last;
   logic                                 out_free, emit;

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign pop_ready = !active_ff;
   assign out_free  = !valid_ff || out_ready;
   assign emit      = active_ff && out_free;
   assign hex_idx   = itoa_pkg::HEX_POS_LAST - pos_ff;

   // Most significant nonzero decimal digit; zero yields position zero.
   always_comb begin
      top_pos = '0;
      for (int i = 1; i < itoa_pkg::DIGIT_COUNT; i++) begin
         if (pop_entry.digits[i] != '0) begin
            top_pos = itoa_pkg::POS_WIDTH'(i);
         end
      end
   end

   always_comb begin
      if (mode_ff == itoa_pkg::OP_HEX) begin
         if (pos_ff == itoa_pkg::HEX_POS_ZERO) begin
            cur_char = itoa_pkg::CHAR_ZERO;
         end else if (pos_ff == itoa_pkg::HEX_POS_X) begin
            cur_char = itoa_pkg::CHAR_X;
         end else begin
            cur_char = itoa_pkg::nibble_to_ascii(digits_ff[hex_idx]);
         end
         cur_last = (pos_ff == itoa_pkg::HEX_POS_LAST);
      end else begin
         cur_char = itoa_pkg::nibble_to_ascii(digits_ff[pos_ff]);
         cur_last = (pos_ff == '0);
      end
   end

   always_comb begin
      active_in = active_ff;
      mode_in   = mode_ff;
      digits_in = digits_ff;
      pos_in    = pos_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && !out_ready;
      if (!active_ff) begin
         if (pop_valid) begin
            active_in = 1'b1;
            mode_in   = pop_entry.mode;
            digits_in = pop_entry.digits;
            pos_in    = (pop_entry.mode == itoa_pkg::OP_HEX) ?
                        itoa_pkg::HEX_POS_ZERO : top_pos;
         end
      end else if (emit) begin
         valid_in = 1'b1;
         char_in  = cur_char;
         last_in  = cur_last;
         // Hex counts up through its ten positions, decimal counts down to digit zero.
         pos_in   = (mode_ff == itoa_pkg::OP_HEX) ? pos_ff + 1'b1 : pos_ff - 1'b1;
         if (cur_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      mode_ff   <= mode_in;
      digits_ff <= digits_in;
      pos_ff    <= pos_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

// ----- rtl/itoa_checker.sv -----
// Port-level checks of the integer to ASCII formatter, bound to its top level.
// Depends on integer_to_ascii_formatter_unit and itoa_pkg.
`default_nettype none

module itoa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   logic is_digit, is_letter, is_x;

   assign is_digit  = (rsp_tdata >= itoa_pkg::CHAR_ZERO) &&
                      (rsp_tdata <= itoa_pkg::CHAR_ZERO + 8'd9);
   assign is_letter = (rsp_tdata >= itoa_pkg::CHAR_A) &&
                      (rsp_tdata <= itoa_pkg::CHAR_A + 8'd5);
   assign is_x      = (rsp_tdata == itoa_pkg::CHAR_X);

   // A response held back by the consumer keeps its character and marker.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // Reset leaves no stale character on the output.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Only decimal digits, upper-case hex letters and the x of the prefix appear.
   a_rsp_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> is_digit || is_letter || is_x)
      else $error("response character outside the output alphabet");

   // The x of the hex prefix is never marked as the last character.
   a_x_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && is_x |-> !rsp_tlast)
      else $error("hex prefix marked as last character");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (.*);

`default_nettype wire
